/* sv/ohash_pkg.sv */
// shared types and constants of the open addressing hash table
`default_nettype none
package ohash_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = 11;
    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int DIV_BITS    = 4;
    localparam int DIV_STEPS   = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [SIZE_W-1:0]    SIZE_RESET     = 11'd1024;

    typedef enum logic [1:0] {
        REQ_FIND   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_OCC  = 2'd1,
        SLOT_DEL  = 2'd2
    } slot_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_NOTFOUND = 2'd1,
        RES_FULL     = 2'd2
    } res_t;

    typedef struct packed {
        req_t              req;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [ADDR_W-1:0] home;
    } job_t;

    typedef struct packed {
        slot_t             st;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } slot_entry_t;

    localparam int JOB_W   = $bits(job_t);
    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_CHECK,
        B_RESP
    } back_state_t;
endpackage
`default_nettype wire

/* sv/ohash_ram.sv */
// generic single port ram with registered read
`default_nettype none
module ohash_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

/* sv/ohash_front.sv */
// front end: accepts items and computes the home slot by digit-serial modulo
`default_nettype none
module ohash_front
    import ohash_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              hold,
    input  wire logic [SIZE_W-1:0] size,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        req_type,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [VAL_W-1:0]  value,
    output logic                   push,
    output job_t                   push_job,
    input  wire logic              q_full
);
    front_state_t         state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [KEY_W-1:0]     shift_reg, shift_next;
    job_t                 job_reg, job_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        shift_reg <= shift_next;
        job_reg   <= job_next;
    end

    always_comb
    begin
        logic [SIZE_W:0] t;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        job_next   = job_reg;
        in_ready   = 1'b0;
        push       = 1'b0;
        push_job   = job_reg;
        case (state_reg)
            F_IDLE:
            begin
                in_ready = !hold;
                if (in_valid && !hold)
                begin
                    job_next.req   = req_t'(req_type);
                    job_next.key   = key;
                    job_next.value = value;
                    job_next.home  = '0;
                    shift_next     = key;
                    rem_next       = '0;
                    cnt_next       = '0;
                    state_next     = F_DIV;
                end
            end
            F_DIV:
            begin
                // restoring remainder, a few key bits per cycle, msb first
                t = '0;
                for (int j = 0; j < DIV_BITS; j++)
                begin
                    t = {rem_next, shift_reg[KEY_W-1-j]};
                    if (t >= {1'b0, size})
                    begin
                        t = t - {1'b0, size};
                    end
                    rem_next = t[SIZE_W-1:0];
                end
                shift_next = shift_reg << DIV_BITS;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push_job.home = rem_reg[ADDR_W-1:0];
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

/* sv/ohash_fifo.sv */
// two entry queue of jobs between front and back
`default_nettype none
module ohash_fifo
    import ohash_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);
    job_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_job;
        end
    end
endmodule
`default_nettype wire

/* sv/ohash_back.sv */
// back end: clears the slot store, walks probe sequences, updates and answers
`default_nettype none
module ohash_back
    import ohash_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SIZE_W-1:0] size,
    input  wire logic              probe_mode,
    input  job_t                   head,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   clearing,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             status,
    output logic [VAL_W-1:0]       found_value,
    output logic [SIZE_W-1:0]      element_count,
    output logic [31:0]            comparison_count
);
    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [SIZE_W-1:0] count_reg, count_next;
    logic [31:0]       tally_reg, tally_next;
    job_t              job_reg, job_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] step_reg, step_next;
    res_t              res_reg, res_next;
    logic [VAL_W-1:0]  fval_reg, fval_next;
    logic              ov_reg, ov_next;
    logic [1:0]        st_out_reg, st_out_next;
    logic [VAL_W-1:0]  fv_out_reg, fv_out_next;
    logic [SIZE_W-1:0] ec_out_reg, ec_out_next;
    logic [31:0]       cc_out_reg, cc_out_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    slot_entry_t       ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;
    slot_entry_t       rd;

    assign rd = slot_entry_t'(ram_rdata);

    ohash_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign clearing         = (state_reg == B_CLEAR);
    assign out_valid        = ov_reg;
    assign status           = st_out_reg;
    assign found_value      = fv_out_reg;
    assign element_count    = ec_out_reg;
    assign comparison_count = cc_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            tally_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            tally_reg <= tally_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        k_reg      <= k_next;
        i_reg      <= i_next;
        step_reg   <= step_next;
        res_reg    <= res_next;
        fval_reg   <= fval_next;
        st_out_reg <= st_out_next;
        fv_out_reg <= fv_out_next;
        ec_out_reg <= ec_out_next;
        cc_out_reg <= cc_out_next;
    end

    always_comb
    begin
        logic [SIZE_W:0] s;
        logic            one_slot;
        logic            done;
        state_next  = state_reg;
        clr_next    = clr_reg;
        count_next  = count_reg;
        tally_next  = tally_reg;
        job_next    = job_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        step_next   = step_reg;
        res_next    = res_reg;
        fval_next   = fval_reg;
        ov_next     = ov_reg;
        st_out_next = st_out_reg;
        fv_out_next = fv_out_reg;
        ec_out_next = ec_out_reg;
        cc_out_next = cc_out_reg;
        pop         = 1'b0;
        ram_we      = 1'b0;
        ram_addr    = k_reg;
        ram_wdata   = rd;
        one_slot    = (size == SIZE_W'(1));
        done        = 1'b0;
        s           = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            B_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_reg;
                ram_wdata.st = SLOT_FREE;
                clr_next     = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop       = 1'b1;
                    job_next  = head;
                    k_next    = head.home;
                    i_next    = '0;
                    step_next = one_slot ? '0 : ADDR_W'(1);
                    fval_next = '0;
                    res_next  = RES_OK;
                    if (head.req == REQ_CLEAR)
                    begin
                        tally_next = '0;
                        state_next = B_RESP;
                    end
                    else if (head.req == REQ_INSERT && count_reg >= size)
                    begin
                        res_next   = RES_FULL;
                        state_next = B_RESP;
                    end
                    else
                    begin
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE:
            begin
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                tally_next = tally_reg + 32'd1;
                if (job_reg.req == REQ_INSERT)
                begin
                    if (rd.st != SLOT_OCC)
                    begin
                        ram_we          = 1'b1;
                        ram_wdata.st    = SLOT_OCC;
                        ram_wdata.key   = job_reg.key;
                        ram_wdata.value = job_reg.value;
                        count_next      = count_reg + 1'b1;
                        done            = 1'b1;
                    end
                end
                else
                begin
                    if (rd.st == SLOT_FREE)
                    begin
                        res_next = RES_NOTFOUND;
                        done     = 1'b1;
                    end
                    else if (rd.st == SLOT_OCC && rd.key == job_reg.key)
                    begin
                        done = 1'b1;
                        if (job_reg.req == REQ_FIND)
                        begin
                            fval_next = rd.value;
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            ram_wdata.st = SLOT_DEL;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                    end
                end

                if (done)
                begin
                    state_next = B_RESP;
                end
                else if ({1'b0, i_reg} == size - 1'b1)
                begin
                    // walk cap reached without a deciding slot
                    res_next   = (job_reg.req == REQ_INSERT) ? RES_FULL : RES_NOTFOUND;
                    state_next = B_RESP;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    if (probe_mode)
                    begin
                        s = {1'b0, k_reg} + {1'b0, step_reg};
                    end
                    else
                    begin
                        s = {1'b0, k_reg} + SIZE_W'(1);
                    end
                    if (s >= {1'b0, size})
                    begin
                        s = s - {1'b0, size};
                    end
                    k_next = s[ADDR_W-1:0];
                    // next odd increment of i*i, kept below size
                    s = {1'b0, step_reg} + SIZE_W'(2);
                    if (s >= {1'b0, size})
                    begin
                        s = s - {1'b0, size};
                    end
                    step_next = one_slot ? '0 : s[ADDR_W-1:0];
                    state_next = B_PROBE;
                end
            end
            B_RESP:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next     = 1'b1;
                    st_out_next = res_reg;
                    fv_out_next = fval_reg;
                    ec_out_next = count_reg;
                    cc_out_next = tally_reg;
                    state_next  = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE) |-> ({1'b0, k_reg} < size))
        else $error("probe slot beyond table size");

    a_check_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CHECK) |-> ($past(state_reg) == B_PROBE))
        else $error("slot checked without a read");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SIZE_W'(TABLE_DEPTH))
        else $error("element count above depth");

    a_no_pop_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !pop)
        else $error("job taken during clearing pass");
endmodule
`default_nettype wire

/* sv/open_addressing_hash_table.sv */
// open addressing hash table engine, top level
// channels: in (in_valid/in_ready, req_type, key, value) carries requests;
// out (out_valid/out_ready, status, found_value, element_count,
// comparison_count) carries one result item per request; cfg
// (cfg_valid/cfg_ready, cfg_index, cfg_data) writes table_size (0) and
// probe_mode (1), always ready, to be used only while the engine is idle.
// the engine works in order: 8 modulo steps of 4 key bits per cycle give the
// home slot, the job passes the queue, each slot examined takes a registered
// ram read, then a check, and the result goes to the output register. a walk
// is capped at table_size slots. the front computes the next home slot while
// the back walks; the front takes each item through accept, 8 modulo steps
// and push, the back through pop, a read and a check per slot examined, and
// a response; the slower of the two sets the rate.
// reset: asynchronous, active low; afterwards a clearing pass over all 1024
// slots marks every slot free, with in_ready low; config writes are taken.
// stall: a held result waits in the output register; the back then holds
// its next item and the two entry queue and front fill before in_ready drops.
`default_nettype none
module open_addressing_hash_table
    import ohash_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            req_type,
    input  wire logic [KEY_W-1:0]      key,
    input  wire logic [VAL_W-1:0]      value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic [VAL_W-1:0]           found_value,
    output logic [SIZE_W-1:0]          element_count,
    output logic [31:0]                comparison_count,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);
    logic [SIZE_W-1:0] size_cfg_reg;
    logic              mode_reg;
    logic [SIZE_W-1:0] size;
    logic              clearing;
    logic              push, pop, q_empty, q_full;
    job_t              push_job, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= SIZE_RESET;
            mode_reg     <= 1'b1;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_TABLE_SIZE)
            begin
                size_cfg_reg <= cfg_data;
            end
            else if (cfg_index == CFG_PROBE_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
        end
    end

    // zero acts as one slot, anything above the depth as the full depth
    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            size = SIZE_W'(1);
        end
        else if (size_cfg_reg > SIZE_W'(TABLE_DEPTH))
        begin
            size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            size = size_cfg_reg;
        end
    end

    ohash_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .size     (size),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .key      (key),
        .value    (value),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    ohash_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    ohash_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .size             (size),
        .probe_mode       (mode_reg),
        .head             (head),
        .q_empty          (q_empty),
        .pop              (pop),
        .clearing         (clearing),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .found_value      (found_value),
        .element_count    (element_count),
        .comparison_count (comparison_count)
    );
endmodule
`default_nettype wire

/* dv/testbench.sv */
// self-checking testbench of the open addressing hash table engine
`timescale 1ns / 1ps
module testbench;
    import ohash_pkg::*;

    typedef struct {
        req_t        req;
        logic [31:0] key;
        logic [31:0] value;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic [10:0] element_count;
        logic [31:0] comparison_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] req_type = '0;
    logic [31:0] key = '0;
    logic [31:0] value = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] status;
    logic [31:0] found_value;
    logic [10:0] element_count;
    logic [31:0] comparison_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    open_addressing_hash_table dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // shadow copy of the table
    slot_t       tbl_st [TABLE_DEPTH];
    logic [31:0] tbl_key [TABLE_DEPTH];
    logic [31:0] tbl_val [TABLE_DEPTH];
    int unsigned shadow_count;
    logic [31:0] shadow_tally;
    int unsigned cur_size;
    logic        cur_quad;

    request_t pending_reqs[$];
    answer_t  awaited_answers[$];
    int errors = 0;
    int answers_seen = 0;
    int items_sent = 0;
    bit hold_sender = 0;

    function automatic int unsigned size_in_use();
        if (cur_size == 0) return 1;
        if (cur_size > TABLE_DEPTH) return TABLE_DEPTH;
        return cur_size;
    endfunction

    // returns slot index or -1
    function automatic int probe_walk(logic [31:0] k, bit for_insert);
        int unsigned sz;
        int unsigned home;
        int unsigned idx;
        longint unsigned off;
        sz = size_in_use();
        home = k % sz;
        for (int unsigned i = 0; i < sz; i++)
        begin
            off = cur_quad ? longint'(i) * longint'(i) : longint'(i);
            idx = (longint'(home) + off) % sz;
            shadow_tally = shadow_tally + 1;
            if (for_insert)
            begin
                if (tbl_st[idx] != SLOT_OCC) return idx;
            end
            else
            begin
                if (tbl_st[idx] == SLOT_FREE) return -1;
                if (tbl_st[idx] == SLOT_OCC && tbl_key[idx] == k) return idx;
            end
        end
        return -1;
    endfunction

    function automatic answer_t table_answer(request_t r);
        answer_t a;
        int s;
        a.status = RES_OK;
        a.found_value = '0;
        case (r.req)
            REQ_FIND:
            begin
                s = probe_walk(r.key, 0);
                if (s < 0) a.status = RES_NOTFOUND;
                else a.found_value = tbl_val[s];
            end
            REQ_INSERT:
            begin
                if (shadow_count >= size_in_use()) a.status = RES_FULL;
                else
                begin
                    s = probe_walk(r.key, 1);
                    if (s < 0) a.status = RES_FULL;
                    else
                    begin
                        tbl_st[s] = SLOT_OCC;
                        tbl_key[s] = r.key;
                        tbl_val[s] = r.value;
                        shadow_count++;
                    end
                end
            end
            REQ_REMOVE:
            begin
                s = probe_walk(r.key, 0);
                if (s < 0) a.status = RES_NOTFOUND;
                else
                begin
                    tbl_st[s] = SLOT_DEL;
                    if (shadow_count > 0) shadow_count--;
                end
            end
            default: shadow_tally = '0;
        endcase
        a.element_count = shadow_count[10:0];
        a.comparison_count = shadow_tally;
        return a;
    endfunction

    // driver: bursts with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            items_sent++;
            awaited_answers.push_back(table_answer(pending_reqs.pop_front()));
        end
        if (!in_valid || in_ready)
        begin
            if (in_valid && in_ready && burst_left > 0) burst_left--;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (hold_sender || pending_reqs.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 30);
                end
                // the head of the queue is the item on the wires
                req_type <= pending_reqs[0].req;
                key <= pending_reqs[0].key;
                value <= pending_reqs[0].value;
                in_valid <= (gap_left == 0);
            end
        end
    end

    // monitor with its own stall pattern
    int stall_phase = 0;
    always @(posedge clk)
    begin
        answer_t e;
        if (out_valid && out_ready)
        begin
            answers_seen++;
            if (awaited_answers.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result status %0d", $realtime, status);
            end
            else
            begin
                e = awaited_answers.pop_front();
                if (status !== e.status || found_value !== e.found_value ||
                    element_count !== e.element_count ||
                    comparison_count !== e.comparison_count)
                begin
                    errors++;
                    $display("%0t: expected st %0d val %h cnt %0d cmp %0d, got st %0d val %h cnt %0d cmp %0d",
                             $realtime, e.status, e.found_value, e.element_count,
                             e.comparison_count, status, found_value, element_count,
                             comparison_count);
                end
            end
        end
        stall_phase = (stall_phase + 1) % 64;
        if (stall_phase < 24) out_ready <= 1'b1;
        else if (stall_phase < 40) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 2) == 0);
    end

    task automatic queue_item(req_t r, logic [31:0] k, logic [31:0] v);
        request_t q;
        q.req = r;
        q.key = k;
        q.value = v;
        pending_reqs.push_back(q);
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && !in_valid);
        wait (awaited_answers.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TABLE_SIZE) cur_size = d;
        else cur_quad = d[0];
    endtask

    // random phase: mostly keys from a small pool so walks hit stored entries
    task automatic random_phase(int n, int unsigned pool);
        int unsigned sel;
        logic [31:0] k;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            k = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, pool);
            if (sel < 40) queue_item(REQ_INSERT, k, $urandom());
            else if (sel < 70) queue_item(REQ_FIND, k, $urandom());
            else if (sel < 97) queue_item(REQ_REMOVE, k, $urandom());
            else queue_item(REQ_CLEAR, $urandom(), $urandom());
        end
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            tbl_st[i] = SLOT_FREE;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        shadow_count = 0;
        shadow_tally = '0;
        cur_size = SIZE_RESET;
        cur_quad = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, each request, empty finds, duplicates, counter clear
        queue_item(REQ_FIND, 32'hFFFF_FFFF, '0);
        queue_item(REQ_REMOVE, 32'd0, '0);
        queue_item(REQ_INSERT, 32'd0, 32'hFFFF_FFFF);
        queue_item(REQ_INSERT, 32'd1024, 32'h0);
        queue_item(REQ_INSERT, 32'd1024, 32'h5A5A_A5A5);
        queue_item(REQ_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        queue_item(REQ_FIND, 32'd1024, '0);
        queue_item(REQ_FIND, 32'hFFFF_FFFF, '0);
        queue_item(REQ_REMOVE, 32'd0, '0);
        queue_item(REQ_FIND, 32'd1024, '0);
        queue_item(REQ_INSERT, 32'd2048, 32'h1234_5678);
        queue_item(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(REQ_FIND, 32'd2048, '0);
        drain();

        // tiny table: full, walk cap, unreachable entries beyond the size
        set_register(CFG_TABLE_SIZE, 11'd4);
        set_register(CFG_PROBE_MODE, 1'b0);
        for (int i = 0; i < 6; i++) queue_item(REQ_INSERT, i * 4, i);
        queue_item(REQ_FIND, 32'd7, '0);
        queue_item(REQ_REMOVE, 32'd8, '0);
        queue_item(REQ_INSERT, 32'd9, 32'd9);
        drain();
        set_register(CFG_TABLE_SIZE, 11'd0);
        random_phase(15, 4);
        drain();
        set_register(CFG_TABLE_SIZE, 11'h7FF);
        set_register(CFG_PROBE_MODE, 1'b1);
        random_phase(300, 3000);
        // pause the sender mid stream until every result is back
        wait (pending_reqs.size() < 150);
        hold_sender = 1;
        wait (!in_valid && awaited_answers.size() == 0);
        repeat (20) @(posedge clk);
        hold_sender = 0;
        drain();

        set_register(CFG_TABLE_SIZE, 11'd8);
        random_phase(350, 20);
        drain();
        set_register(CFG_PROBE_MODE, 1'b0);
        random_phase(350, 20);
        drain();
        set_register(CFG_TABLE_SIZE, 11'd1);
        random_phase(100, 3);
        drain();
        set_register(CFG_TABLE_SIZE, 11'd37);
        set_register(CFG_PROBE_MODE, 1'b1);
        random_phase(420, 90);
        drain();

        $display("covered %0d requests and %0d results over table sizes 0 to 2047",
                 items_sent, answers_seen);
        $display("with linear and quadratic probing, full tables and tombstones");
        if (errors == 0 && awaited_answers.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("testbench: FAIL");
        $finish;
    end
endmodule

/* files.f */
sv/ohash_pkg.sv
sv/ohash_ram.sv
sv/ohash_front.sv
sv/ohash_fifo.sv
sv/ohash_back.sv
sv/open_addressing_hash_table.sv
dv/testbench.sv
